/* hdl/pbd_pkg.sv */
// Shared types, register indexes and helpers for the periodic boundary distance block.
package pbd_pkg;

   localparam int COORD_W = 32;
   localparam int SQ_W    = 2 * COORD_W;
   localparam int ROOT_W  = COORD_W;
   localparam int REM_W   = ROOT_W + 2;

   localparam logic [2:0] REG_LOW_BOUND_X  = 3'd0;
   localparam logic [2:0] REG_HIGH_BOUND_X = 3'd1;
   localparam logic [2:0] REG_LOW_BOUND_Y  = 3'd2;
   localparam logic [2:0] REG_HIGH_BOUND_Y = 3'd3;
   localparam logic [2:0] REG_THREE_D_MODE = 3'd4;

   // one slot of the square root chain
   typedef struct packed {
      logic              valid;
      logic              over;
      logic [SQ_W-1:0]   rad;
      logic [REM_W-1:0]  rem;
      logic [ROOT_W-1:0] root;
   } pbd_cell_type;

   // exact magnitude of the difference of two signed coordinates
   function automatic logic [COORD_W-1:0] abs_diff(input logic signed [COORD_W-1:0] a,
                                                   input logic signed [COORD_W-1:0] b);
      logic signed [COORD_W:0] d;
      logic signed [COORD_W:0] mag;
      d   = {a[COORD_W-1], a} - {b[COORD_W-1], b};
      mag = d[COORD_W] ? -d : d;
      return mag[COORD_W-1:0];
   endfunction

endpackage

/* hdl/periodic_boundary_distance_top.sv */
// Periodic boundary distance: front end, squares, sums and a 32-cell square root chain.
// A request runs through the front stages and then the 32 chain cells to rsp_valid, held by any output stall.
// Throughput: one item per cycle; the whole pipeline holds while the result waits.
// The square root chain resolves one root bit per cell, with one cell per stage.
// Reset (synchronous, active high) clears all stage valid bits and the box registers.
// Box registers must only be written while no item is in flight.
module periodic_boundary_distance_top (
   input  logic                                clock,
   input  logic                                reset,
   input  logic                                req_valid,
   output logic                                req_ready,
   input  logic signed [pbd_pkg::COORD_W-1:0]  req_first_x,
   input  logic signed [pbd_pkg::COORD_W-1:0]  req_first_y,
   input  logic signed [pbd_pkg::COORD_W-1:0]  req_first_z,
   input  logic signed [pbd_pkg::COORD_W-1:0]  req_second_x,
   input  logic signed [pbd_pkg::COORD_W-1:0]  req_second_y,
   input  logic signed [pbd_pkg::COORD_W-1:0]  req_second_z,
   output logic                                rsp_valid,
   input  logic                                rsp_ready,
   output logic        [pbd_pkg::COORD_W-1:0]  rsp_distance,
   input  logic                                csr_wr_en,
   input  logic        [2:0]                   csr_index,
   input  logic        [pbd_pkg::COORD_W-1:0]  csr_wdata
);
   import pbd_pkg::*;

   localparam int FRONT_STAGES = 6;

   // ---------------- configuration registers ----------------
   logic signed [COORD_W-1:0] low_x_ff, high_x_ff, low_y_ff, high_y_ff;
   logic                      three_d_ff;

   always_ff @(posedge clock) begin
      if (reset) begin
         low_x_ff   <= '0;
         high_x_ff  <= '0;
         low_y_ff   <= '0;
         high_y_ff  <= '0;
         three_d_ff <= 1'b0;
      end else if (csr_wr_en) begin
         case (csr_index)
            REG_LOW_BOUND_X:  low_x_ff   <= csr_wdata;
            REG_HIGH_BOUND_X: high_x_ff  <= csr_wdata;
            REG_LOW_BOUND_Y:  low_y_ff   <= csr_wdata;
            REG_HIGH_BOUND_Y: high_y_ff  <= csr_wdata;
            REG_THREE_D_MODE: three_d_ff <= csr_wdata[0];
            default: ;  // unmapped index, write dropped
         endcase
      end
   end

   // ---------------- pipeline control ----------------
   // Single global advance: everything moves unless the finished result is
   // stuck at the output. Bubbles travel as cleared valid bits.
   pbd_cell_type chain [ROOT_W+1];
   logic         advance;

   assign advance   = !chain[ROOT_W].valid || rsp_ready;
   assign req_ready = advance;

   logic [FRONT_STAGES-1:0] front_valid_ff;

   always_ff @(posedge clock) begin
      if (reset) begin
         front_valid_ff <= '0;
      end else if (advance) begin
         front_valid_ff <= {front_valid_ff[FRONT_STAGES-2:0], req_valid};
      end
   end

   // ---------------- stages 1-3: axis distances ----------------
   logic [COORD_W-1:0] dx, dy;

   pbd_axis u_axis_x (
      .clock    (clock),
      .advance  (advance),
      .p        (req_first_x),
      .q        (req_second_x),
      .lo       (low_x_ff),
      .hi       (high_x_ff),
      .dist_out (dx)
   );

   pbd_axis u_axis_y (
      .clock    (clock),
      .advance  (advance),
      .p        (req_first_y),
      .q        (req_second_y),
      .lo       (low_y_ff),
      .hi       (high_y_ff),
      .dist_out (dy)
   );

   // z is not wrapped; in 2-D mode it is forced to zero so it adds nothing
   logic [COORD_W-1:0] dz1_ff, dz2_ff, dz3_ff;

   // ---------------- stages 4-6: squares and sums ----------------
   logic [SQ_W-1:0] sqx_ff, sqy_ff, sqz_ff, sqz5_ff;
   logic [SQ_W-1:0] sum_xy_ff, sum_ff;
   logic            over_xy_ff, over_ff;
   logic [SQ_W:0]   sum_xy_in, sum_in;

   assign sum_xy_in = {1'b0, sqx_ff} + {1'b0, sqy_ff};
   assign sum_in    = {1'b0, sum_xy_ff} + {1'b0, sqz5_ff};

   always_ff @(posedge clock) begin
      if (advance) begin
         dz1_ff     <= three_d_ff ? abs_diff(req_first_z, req_second_z) : '0;
         dz2_ff     <= dz1_ff;
         dz3_ff     <= dz2_ff;
         sqx_ff     <= SQ_W'(dx) * SQ_W'(dx);
         sqy_ff     <= SQ_W'(dy) * SQ_W'(dy);
         sqz_ff     <= SQ_W'(dz3_ff) * SQ_W'(dz3_ff);
         sum_xy_ff  <= sum_xy_in[SQ_W-1:0];
         over_xy_ff <= sum_xy_in[SQ_W];
         sqz5_ff    <= sqz_ff;
         sum_ff     <= sum_in[SQ_W-1:0];
         over_ff    <= over_xy_ff | sum_in[SQ_W];
      end
   end

   // ---------------- square root chain ----------------
   // Each cell takes the next two radicand bits from the top and settles
   // one root bit; the root of a 64-bit value always fits 32 bits.
   always_comb begin
      chain[0].valid = front_valid_ff[FRONT_STAGES-1];
      chain[0].over  = over_ff;
      chain[0].rad   = sum_ff;
      chain[0].rem   = '0;
      chain[0].root  = '0;
   end

   for (genvar i = 0; i < ROOT_W; i++) begin : g_cell
      pbd_sqrt_cell u_cell (
         .clock    (clock),
         .reset    (reset),
         .advance  (advance),
         .cell_in  (chain[i]),
         .cell_out (chain[i+1])
      );
   end

   // last cell register doubles as the output register
   assign rsp_valid    = chain[ROOT_W].valid;
   assign rsp_distance = chain[ROOT_W].over ? '1 : chain[ROOT_W].root;

`ifndef SYNTHESIS
   // a result waiting at the output must hold off new requests
   a_stall_blocks_req: assert property (@(posedge clock) disable iff (reset)
      (rsp_valid && !rsp_ready) |-> !req_ready)
      else $error("request accepted while output stalled");

   // reset empties the pipeline
   a_reset_clears: assert property (@(posedge clock)
      reset |=> (!rsp_valid && front_valid_ff == '0))
      else $error("pipeline not empty after reset");

   // a stalled result keeps its value
   a_stall_holds: assert property (@(posedge clock) disable iff (reset)
      (rsp_valid && !rsp_ready) |=> $stable(rsp_distance))
      else $error("result changed while stalled");
`endif

endmodule

/* hdl/pbd_axis.sv */
// Three-stage wrapped distance along one periodic axis.
module pbd_axis (
   input  logic                                 clock,
   input  logic                                 advance,
   input  logic signed [pbd_pkg::COORD_W-1:0]   p,
   input  logic signed [pbd_pkg::COORD_W-1:0]   q,
   input  logic signed [pbd_pkg::COORD_W-1:0]   lo,
   input  logic signed [pbd_pkg::COORD_W-1:0]   hi,
   output logic        [pbd_pkg::COORD_W-1:0]   dist_out
);
   import pbd_pkg::*;

   logic [COORD_W-1:0] plain_ff, pl_ff, ph_ff, ql_ff, qh_ff;
   logic [COORD_W-1:0] plain2_ff, pe_ff, qe_ff;
   logic [COORD_W-1:0] dist_ff, dist_in;
   logic [COORD_W:0]   wrap;

   always_comb begin
      wrap = {1'b0, pe_ff} + {1'b0, qe_ff};
      if (wrap[COORD_W]) begin
         wrap[COORD_W-1:0] = '1;
      end
      dist_in = (plain2_ff < wrap[COORD_W-1:0]) ? plain2_ff : wrap[COORD_W-1:0];
   end

   always_ff @(posedge clock) begin
      if (advance) begin
         plain_ff  <= abs_diff(p, q);
         pl_ff     <= abs_diff(p, lo);
         ph_ff     <= abs_diff(p, hi);
         ql_ff     <= abs_diff(q, lo);
         qh_ff     <= abs_diff(q, hi);
         plain2_ff <= plain_ff;
         pe_ff     <= (pl_ff < ph_ff) ? pl_ff : ph_ff;
         qe_ff     <= (ql_ff < qh_ff) ? ql_ff : qh_ff;
         dist_ff   <= dist_in;
      end
   end

   assign dist_out = dist_ff;

endmodule

/* hdl/pbd_sqrt_cell.sv */
// One digit of the square root chain: resolves one root bit per cell.
module pbd_sqrt_cell (
   input  logic                  clock,
   input  logic                  reset,
   input  logic                  advance,
   input  pbd_pkg::pbd_cell_type cell_in,
   output pbd_pkg::pbd_cell_type cell_out
);
   import pbd_pkg::*;

   pbd_cell_type     cell_ff, cell_nx;
   logic [REM_W+1:0] rem_sh;
   logic [REM_W+1:0] trial;
   logic [REM_W+1:0] diff;

   always_comb begin
      rem_sh  = {cell_in.rem, cell_in.rad[SQ_W-1 -: 2]};
      trial   = {2'b00, cell_in.root, 2'b01};
      diff    = rem_sh - trial;
      cell_nx = cell_in;
      cell_nx.rad = {cell_in.rad[SQ_W-3:0], 2'b00};
      if (rem_sh >= trial) begin
         cell_nx.rem  = diff[REM_W-1:0];
         cell_nx.root = {cell_in.root[ROOT_W-2:0], 1'b1};
      end else begin
         cell_nx.rem  = rem_sh[REM_W-1:0];
         cell_nx.root = {cell_in.root[ROOT_W-2:0], 1'b0};
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         cell_ff.valid <= 1'b0;
      end else if (advance) begin
         cell_ff <= cell_nx;
      end
   end

   assign cell_out = cell_ff;

endmodule

/* tb/periodic_boundary_distance_top_tb.sv */
// Self-checking testbench for the periodic boundary distance block: box settings, traffic, scoreboard.
`timescale 1ns / 1ps

module periodic_boundary_distance_top_tb;
   import pbd_pkg::*;

   // Q16.16 helpers for building coordinates
   localparam logic signed [COORD_W-1:0] Q_ONE   = 32'sd65536;
   localparam logic signed [COORD_W-1:0] Q_MIN   = 32'sh8000_0000;
   localparam logic signed [COORD_W-1:0] Q_MAX   = 32'sh7FFF_FFFF;
   // pipeline latency, rounded up, for the quiet time after a drain
   localparam int SETTLE_CYCLES = 50;
   // length of the receiver hold-off used to back the pipeline up
   localparam int HOLD_CYCLES   = 400;

   // one request: two points
   typedef struct packed {
      logic signed [COORD_W-1:0] first_x;
      logic signed [COORD_W-1:0] first_y;
      logic signed [COORD_W-1:0] first_z;
      logic signed [COORD_W-1:0] second_x;
      logic signed [COORD_W-1:0] second_y;
      logic signed [COORD_W-1:0] second_z;
   } point_pair_type;

   // Scoreboard: holds its own copy of the box registers, predicts the wrapped
   // distance of each accepted pair and matches responses in order.
   class distance_scoreboard;
      logic signed [COORD_W-1:0] lo_x, hi_x, lo_y, hi_y;
      logic                      three_d;
      logic [COORD_W-1:0]        expected_q[$];
      int                        errors;

      function new();
         lo_x    = '0;
         hi_x    = '0;
         lo_y    = '0;
         hi_y    = '0;
         three_d = 1'b0;
         errors  = 0;
      endfunction

      // mirror of a register write; indexes past the list are dropped
      function void set_reg(logic [2:0] idx, logic [COORD_W-1:0] data);
         case (idx)
            REG_LOW_BOUND_X:  lo_x = data;
            REG_HIGH_BOUND_X: hi_x = data;
            REG_LOW_BOUND_Y:  lo_y = data;
            REG_HIGH_BOUND_Y: hi_y = data;
            REG_THREE_D_MODE: three_d = data[0];
            default: ;
         endcase
      endfunction

      // exact |p - q|, always fits 32 unsigned bits
      function logic [COORD_W-1:0] gap(logic signed [COORD_W-1:0] p,
                                       logic signed [COORD_W-1:0] q);
         logic signed [COORD_W:0] d;
         if (p >= q)
            d = 33'(p) - 33'(q);
         else
            d = 33'(q) - 33'(p);
         return d[COORD_W-1:0];
      endfunction

      // min of the plain gap and the saturated sum of the nearer edge gaps
      function logic [COORD_W-1:0] axis_dist(logic signed [COORD_W-1:0] p,
                                             logic signed [COORD_W-1:0] q,
                                             logic signed [COORD_W-1:0] lo,
                                             logic signed [COORD_W-1:0] hi);
         logic [COORD_W-1:0] plain, p_edge, q_edge, wrap;
         logic [COORD_W:0]   wrap_sum;
         plain    = gap(p, q);
         p_edge   = (gap(p, lo) < gap(p, hi)) ? gap(p, lo) : gap(p, hi);
         q_edge   = (gap(q, lo) < gap(q, hi)) ? gap(q, lo) : gap(q, hi);
         wrap_sum = {1'b0, p_edge} + {1'b0, q_edge};
         wrap     = wrap_sum[COORD_W] ? '1 : wrap_sum[COORD_W-1:0];
         return (plain < wrap) ? plain : wrap;
      endfunction

      // floor of the square root of a Q32.32 value, one bit per try
      function logic [COORD_W-1:0] floor_root(logic [SQ_W-1:0] x);
         logic [SQ_W-1:0] root, trial;
         root = '0;
         for (int i = COORD_W - 1; i >= 0; i--) begin
            trial = root | (64'd1 << i);
            if (trial * trial <= x)
               root = trial;
         end
         return root[COORD_W-1:0];
      endfunction

      function logic [COORD_W-1:0] predict_distance(point_pair_type p);
         logic [SQ_W-1:0] dx, dy, dz;
         logic [SQ_W:0]   acc;
         logic            over;
         dx   = SQ_W'(axis_dist(p.first_x, p.second_x, lo_x, hi_x));
         dy   = SQ_W'(axis_dist(p.first_y, p.second_y, lo_y, hi_y));
         acc  = {1'b0, dx * dx} + {1'b0, dy * dy};
         over = acc[SQ_W];
         if (three_d) begin
            dz   = SQ_W'(gap(p.first_z, p.second_z));
            acc  = {1'b0, acc[SQ_W-1:0]} + {1'b0, dz * dz};
            over = over | acc[SQ_W];
         end
         return over ? '1 : floor_root(acc[SQ_W-1:0]);
      endfunction

      function void note_pair(point_pair_type p);
         expected_q.push_back(predict_distance(p));
      endfunction

      function void check_distance(logic [COORD_W-1:0] got);
         logic [COORD_W-1:0] want;
         if (expected_q.size() == 0) begin
            $display("%0t: unexpected response, distance %h", $time, got);
            errors++;
         end else begin
            want = expected_q.pop_front();
            if (got !== want) begin
               $display("%0t: distance mismatch, expected %h, actual %h", $time, want, got);
               errors++;
            end
         end
      endfunction

      function int pending();
         return expected_q.size();
      endfunction
   endclass

   // ---------------------------------------------------------------------------------------
   // DUT signals; every input starts at a known value
   // ---------------------------------------------------------------------------------------
   logic                      clock        = 1'b0;
   logic                      reset        = 1'b1;
   logic                      req_valid    = 1'b0;
   logic                      req_ready;
   logic signed [COORD_W-1:0] req_first_x  = '0;
   logic signed [COORD_W-1:0] req_first_y  = '0;
   logic signed [COORD_W-1:0] req_first_z  = '0;
   logic signed [COORD_W-1:0] req_second_x = '0;
   logic signed [COORD_W-1:0] req_second_y = '0;
   logic signed [COORD_W-1:0] req_second_z = '0;
   logic                      rsp_valid;
   logic                      rsp_ready    = 1'b0;
   logic        [COORD_W-1:0] rsp_distance;
   logic                      csr_wr_en    = 1'b0;
   logic        [2:0]         csr_index    = '0;
   logic        [COORD_W-1:0] csr_wdata    = '0;

   distance_scoreboard sb = new();

   // idling controls, written only by the main sequence
   int send_idle_pct  = 0;
   int rsp_stall_pct  = 0;
   int hold_requests  = 0;
   // owned by the receiver process
   int hold_served    = 0;
   int hold_left      = 0;

   periodic_boundary_distance_top dut (
      .clock        (clock),
      .reset        (reset),
      .req_valid    (req_valid),
      .req_ready    (req_ready),
      .req_first_x  (req_first_x),
      .req_first_y  (req_first_y),
      .req_first_z  (req_first_z),
      .req_second_x (req_second_x),
      .req_second_y (req_second_y),
      .req_second_z (req_second_z),
      .rsp_valid    (rsp_valid),
      .rsp_ready    (rsp_ready),
      .rsp_distance (rsp_distance),
      .csr_wr_en    (csr_wr_en),
      .csr_index    (csr_index),
      .csr_wdata    (csr_wdata)
   );

   initial begin
      forever #5 clock = ~clock;
   end

   // Watchdog: far beyond the slowest legal run.
   initial begin
      #5ms;
      $display("** periodic_boundary_distance_top: FAILED **");
      $finish;
   end

   // Receiver: checks every response transfer, then picks ready for the next edge.
   // A hold-off request from the main sequence drops ready while hold_left, loaded from
   // HOLD_CYCLES, counts down here, so the pipeline backs up into req_ready.
   always @(posedge clock) begin
      if (!reset && rsp_valid && rsp_ready)
         sb.check_distance(rsp_distance);
      if (hold_served != hold_requests) begin
         hold_served = hold_requests;
         hold_left   = HOLD_CYCLES;
      end
      if (hold_left > 0) begin
         hold_left = hold_left - 1;
         rsp_ready <= 1'b0;
      end else begin
         rsp_ready <= ($urandom_range(99) >= rsp_stall_pct);
      end
   end

   // ---------------------------------------------------------------------------------------
   // Stimulus helpers
   // ---------------------------------------------------------------------------------------
   function automatic point_pair_type make_pair(logic signed [COORD_W-1:0] fx, fy, fz,
                                                logic signed [COORD_W-1:0] sx, sy, sz);
      point_pair_type p;
      p = '{fx, fy, fz, sx, sy, sz};
      return p;
   endfunction

   // offset of up to one unit either way
   function automatic int near_offset();
      return int'($urandom_range(2 * 65536)) - 65536;
   endfunction

   // Coordinate with a bias toward the box: inside it, hugging an edge, at the
   // field extremes, or anywhere at all.
   function automatic logic signed [COORD_W-1:0] rand_coord(logic signed [COORD_W-1:0] lo,
                                                            logic signed [COORD_W-1:0] hi);
      logic signed [COORD_W-1:0] a, b, v;
      logic [COORD_W:0]          span, off;
      a = (lo < hi) ? lo : hi;
      b = (lo < hi) ? hi : lo;
      case ($urandom_range(9))
         0, 1: v = $urandom;
         2:    v = $urandom_range(1) ? Q_MAX : Q_MIN;
         3:    v = lo + near_offset();
         4:    v = hi + near_offset();
         default: begin
            span = {b[COORD_W-1], b} - {a[COORD_W-1], a};
            off  = {1'b0, $urandom} % (span + 1);
            v    = a + off[COORD_W-1:0];
         end
      endcase
      return v;
   endfunction

   function automatic point_pair_type random_pair();
      point_pair_type p;
      p.first_x  = rand_coord(sb.lo_x, sb.hi_x);
      p.first_y  = rand_coord(sb.lo_y, sb.hi_y);
      p.first_z  = rand_coord(-64 * Q_ONE, 64 * Q_ONE);
      // a quarter of the pairs sit close together for short distances
      if ($urandom_range(3) == 0) begin
         p.second_x = p.first_x + near_offset();
         p.second_y = p.first_y + near_offset();
         p.second_z = p.first_z + near_offset();
      end else begin
         p.second_x = rand_coord(sb.lo_x, sb.hi_x);
         p.second_y = rand_coord(sb.lo_y, sb.hi_y);
         p.second_z = rand_coord(-64 * Q_ONE, 64 * Q_ONE);
      end
      return p;
   endfunction

   // One request transfer: optional idle gaps, then hold valid until accepted.
   task automatic send_pair(input point_pair_type p);
      while ($urandom_range(99) < send_idle_pct) begin
         req_valid <= 1'b0;
         @(posedge clock);
      end
      req_valid    <= 1'b1;
      req_first_x  <= p.first_x;
      req_first_y  <= p.first_y;
      req_first_z  <= p.first_z;
      req_second_x <= p.second_x;
      req_second_y <= p.second_y;
      req_second_z <= p.second_z;
      do
         @(posedge clock);
      while (!req_ready);
      sb.note_pair(p);
   endtask

   // Register write; callers drop csr_wr_en after the last one of a burst.
   task automatic write_csr(input logic [2:0] idx, input logic [COORD_W-1:0] data);
      csr_wr_en <= 1'b1;
      csr_index <= idx;
      csr_wdata <= data;
      @(posedge clock);
      sb.set_reg(idx, data);
   endtask

   // Full box setup, plus a write to an index past the register list, which must not land.
   task automatic load_box(input logic [COORD_W-1:0] lx, hx, ly, hy, input logic mode);
      logic [COORD_W-1:0] junk;
      junk = $urandom;
      write_csr(REG_LOW_BOUND_X, lx);
      write_csr(REG_HIGH_BOUND_X, hx);
      write_csr(REG_LOW_BOUND_Y, ly);
      write_csr(REG_HIGH_BOUND_Y, hy);
      // only bit 0 of the mode register counts
      write_csr(REG_THREE_D_MODE, {junk[COORD_W-1:1], mode});
      write_csr(3'(REG_THREE_D_MODE + 1 + $urandom_range(2)), $urandom);
      csr_wr_en <= 1'b0;
   endtask

   // Random traffic, then drain so the box can be changed safely afterwards.
   task automatic run_phase(input int count, input int idle_pct, input int stall_pct);
      send_idle_pct = idle_pct;
      rsp_stall_pct = stall_pct;
      repeat (count) send_pair(random_pair());
      req_valid <= 1'b0;
      while (sb.pending() != 0)
         @(posedge clock);
      repeat (SETTLE_CYCLES) @(posedge clock);
   endtask

   // ---------------------------------------------------------------------------------------
   // Main sequence
   // ---------------------------------------------------------------------------------------
   initial begin
      repeat (5) @(posedge clock);
      reset <= 1'b0;
      @(posedge clock);

      // reset box: both bounds zero on each axis (equal bounds), 2-D
      run_phase(60, 0, 0);

      // box [-10,10] x [-5,5], 3-D, directed corners first
      load_box(-10 * Q_ONE, 10 * Q_ONE, -5 * Q_ONE, 5 * Q_ONE, 1'b1);
      send_idle_pct = 0;
      rsp_stall_pct = 0;
      send_pair(make_pair(0, 0, 0, 0, 0, 0));
      // opposite box corners: wrap distance is zero
      send_pair(make_pair(-10 * Q_ONE, -5 * Q_ONE, 0, 10 * Q_ONE, 5 * Q_ONE, 0));
      // wrap shorter than plain in x only
      send_pair(make_pair(9 * Q_ONE, 0, 0, -9 * Q_ONE, 0, 0));
      // both points midway: the distances to the low and the high edge tie
      send_pair(make_pair(0, 0, 0, 0, 0, Q_ONE));
      send_pair(make_pair(0, 3 * Q_ONE, 0, 5 * Q_ONE, -3 * Q_ONE, Q_ONE));
      send_pair(make_pair(Q_MIN, Q_MIN, Q_MIN, Q_MIN, Q_MIN, Q_MIN));
      send_pair(make_pair(Q_MAX, Q_MAX, Q_MAX, Q_MAX, Q_MAX, Q_MAX));
      // huge differences on every axis: sum of squares overflows, result saturates
      send_pair(make_pair(Q_MIN, Q_MIN, Q_MIN, Q_MAX, Q_MAX, Q_MAX));
      send_pair(make_pair(Q_MAX, Q_MAX, Q_MAX, Q_MIN, Q_MIN, Q_MIN));
      // z alone at full range: largest root without overflow
      send_pair(make_pair(0, 0, Q_MIN, 0, 0, Q_MAX));
      // smallest fractions
      send_pair(make_pair(1, 1, 1, 0, 0, 0));
      send_pair(make_pair(-1, 32'sh0000_FFFF, -1, 1, 0, 32'sh7FFF_0000));
      // points outside the box or on its corner
      send_pair(make_pair(100 * Q_ONE, -200 * Q_ONE, 3, -300 * Q_ONE, 50 * Q_ONE, -3));
      send_pair(make_pair(Q_MIN, 0, 0, Q_MAX, 0, 0));
      send_pair(make_pair(0, Q_MIN, 0, 0, Q_MAX, 0));
      send_pair(make_pair(10 * Q_ONE, 5 * Q_ONE, 7, 10 * Q_ONE, 5 * Q_ONE, 7));
      run_phase(250, 0, 0);

      // box [0,100.5] x [-1000,0], 2-D, sender idles; z must not matter
      load_box(0, 100 * Q_ONE + 32'sh8000, -1000 * Q_ONE, 0, 1'b0);
      send_idle_pct = 61;
      send_pair(make_pair(Q_ONE, Q_ONE, Q_MIN, 2 * Q_ONE, 3 * Q_ONE, Q_MAX));
      send_pair(make_pair(Q_MAX, Q_MIN, 0, Q_MIN, Q_MAX, 0));
      send_pair(make_pair(Q_MIN, Q_MAX, Q_MAX, Q_MAX, Q_MIN, Q_MIN));
      run_phase(250, 61, 0);

      // swapped x bounds, equal y bounds, 3-D, receiver stalls
      load_box(50 * Q_ONE, -50 * Q_ONE, 7 * Q_ONE + 32'sh4000, 7 * Q_ONE + 32'sh4000, 1'b1);
      run_phase(250, 0, 61);

      // box spanning the whole field, 3-D, both sides idle
      load_box(Q_MIN, Q_MAX, Q_MIN, Q_MAX, 1'b1);
      run_phase(250, 35, 35);

      // fully random bounds, 2-D; the receiver holds off long enough to fill the pipe
      load_box($urandom, $urandom, $urandom, $urandom, 1'b0);
      hold_requests = hold_requests + 1;
      run_phase(150, 35, 35);

      // small random box, 3-D, no idling
      load_box(-$urandom_range(1, 100) * Q_ONE, $urandom_range(1, 100) * Q_ONE,
               -$urandom_range(1, 100) * Q_ONE, $urandom_range(1, 100) * Q_ONE, 1'b1);
      run_phase(200, 0, 0);

      // extremes reversed: bounds at the opposite field limits, 2-D
      load_box(Q_MAX, Q_MIN, Q_MAX, Q_MIN, 1'b0);
      run_phase(40, 35, 35);

      if (sb.errors == 0 && sb.pending() == 0) begin
         $display("** periodic_boundary_distance_top: PASSED **");
      end else begin
         $display("** periodic_boundary_distance_top: FAILED **");
      end
      $finish;
   end

endmodule

/* filelist.f */
hdl/pbd_pkg.sv
hdl/pbd_axis.sv
hdl/pbd_sqrt_cell.sv
hdl/periodic_boundary_distance_top.sv
tb/periodic_boundary_distance_top_tb.sv
